// File: rtl/npc_pkg.sv
// shared constants, types and register codes for the near-plane clip and projection block
// no dependencies; every other file of the block refers to this package by scoped names
`default_nettype none

package npc_pkg;

	localparam int CW = 32;
	localparam int FRAC = 16;
	localparam int NEAR_W = 31;
	localparam int SIZE_W = 14;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 31;

	localparam logic [NEAR_W-1:0] NEAR_RST = NEAR_W'(6554);
	localparam logic [SIZE_W-1:0] WIDTH_RST = SIZE_W'(1920);
	localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(1080);

	// divider: dividend, divisor and quotient widths, one quotient bit per stage
	localparam int DIV_NW = 2 * CW;
	localparam int DIV_DW = CW;
	localparam int DIV_QW = CW + 1;
	localparam int DIV_LAT = DIV_QW + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NEAR = 2'd0,
		CFG_WIDTH = 2'd1,
		CFG_HEIGHT = 2'd2
	} cfg_reg_t;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		coord_t w;
	} point_t;

	typedef struct packed {
		point_t sp;
		point_t ep;
	} seg_t;

	typedef struct packed {
		logic [CW-1:0] near;
		logic [SIZE_W-1:0] width;
		logic [SIZE_W-1:0] height;
	} cfg_t;

	typedef struct packed {
		coord_t sx;
		coord_t sy;
		coord_t sd;
		coord_t ex;
		coord_t ey;
		coord_t ed;
		logic clipped;
	} res_t;

endpackage

`default_nettype wire

// File: rtl/npc_seg_if.sv
// segment input channel: valid/ready handshake with two homogeneous endpoints
// depends on npc_pkg
`default_nettype none

interface npc_seg_if;
	logic valid;
	logic ready;
	logic signed [npc_pkg::CW-1:0] start_x;
	logic signed [npc_pkg::CW-1:0] start_y;
	logic signed [npc_pkg::CW-1:0] start_z;
	logic signed [npc_pkg::CW-1:0] start_w;
	logic signed [npc_pkg::CW-1:0] end_x;
	logic signed [npc_pkg::CW-1:0] end_y;
	logic signed [npc_pkg::CW-1:0] end_z;
	logic signed [npc_pkg::CW-1:0] end_w;

	modport source(output valid, start_x, start_y, start_z, start_w,
		end_x, end_y, end_z, end_w, input ready);
	modport sink(input valid, start_x, start_y, start_z, start_w,
		end_x, end_y, end_z, end_w, output ready);
endinterface

`default_nettype wire

// File: rtl/npc_pix_if.sv
// result channel: valid/ready handshake with projected screen coordinates
// depends on npc_pkg
`default_nettype none

interface npc_pix_if;
	logic valid;
	logic ready;
	logic signed [npc_pkg::CW-1:0] screen_start_x;
	logic signed [npc_pkg::CW-1:0] screen_start_y;
	logic signed [npc_pkg::CW-1:0] depth_start;
	logic signed [npc_pkg::CW-1:0] screen_end_x;
	logic signed [npc_pkg::CW-1:0] screen_end_y;
	logic signed [npc_pkg::CW-1:0] depth_end;
	logic was_clipped;

	modport source(output valid, screen_start_x, screen_start_y, depth_start,
		screen_end_x, screen_end_y, depth_end, was_clipped, input ready);
	modport sink(input valid, screen_start_x, screen_start_y, depth_start,
		screen_end_x, screen_end_y, depth_end, was_clipped, output ready);
endinterface

`default_nettype wire

// File: rtl/near_plane_line_clip_project.sv
// Near-plane line clipping and screen projection of 3D segments.
// A segment enters on the seg channel (valid/ready) as two homogeneous endpoints
// in signed Q16.16. A segment with both w values below the near plane is dropped;
// otherwise one result leaves on the pix channel with screen x/y in pixels, depth
// z/w, all saturated, and a flag telling whether an endpoint was moved to the plane.
// Registers (near plane, screen width, screen height) are written through
// cfg_wr_en / cfg_index / cfg_wdata; the user must write them only while no
// segment is in flight, as the block itself does not enforce it. The clip and
// projection pipelines have 4 + 34 + 1 stages each, dominated by the 34-stage
// restoring dividers that retire one quotient bit per stage.
// Throughput is one segment per cycle while pix.ready stays high.
// When the receiver stalls, the finished result moves into a one-entry skid
// register and the whole pipeline then holds; seg.ready drops while that
// register is full and rises again in the cycle after it drains.
// Reset clears all valid bits, including the skid valid bit, and loads the register
// defaults (near 6554, 1920 by 1080); no clearing pass is needed.
// depends on npc_pkg, npc_seg_if, npc_pix_if, npc_clip, npc_proj, npc_div
`default_nettype none

module near_plane_line_clip_project (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic [npc_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [npc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	npc_seg_if.sink seg,
	npc_pix_if.source pix
);
	localparam int NEAR_W = npc_pkg::NEAR_W;
	localparam int SIZE_W = npc_pkg::SIZE_W;
	localparam int CW = npc_pkg::CW;

	logic [NEAR_W-1:0] near_q;
	logic [SIZE_W-1:0] width_q, height_q;
	npc_pkg::cfg_t cfg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q <= npc_pkg::NEAR_RST;
			width_q <= npc_pkg::WIDTH_RST;
			height_q <= npc_pkg::HEIGHT_RST;
		end else if (cfg_wr_en) begin
			unique case (npc_pkg::cfg_reg_t'(cfg_index))
				npc_pkg::CFG_NEAR: near_q <= cfg_wdata[NEAR_W-1:0];
				npc_pkg::CFG_WIDTH: width_q <= cfg_wdata[SIZE_W-1:0];
				npc_pkg::CFG_HEIGHT: height_q <= cfg_wdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// a zero near plane acts as a raw value of one LSB
	always_comb begin
		cfg.near = (near_q == '0) ? CW'(1) : CW'(near_q);
		cfg.width = width_q;
		cfg.height = height_q;
	end

	logic en;
	npc_pkg::seg_t in_seg;
	logic clip_v, clip_flag, res_v;
	npc_pkg::seg_t clip_seg;
	npc_pkg::res_t res;
	logic skid_v_q;
	npc_pkg::res_t skid_q;
	npc_pkg::res_t out_r;

	assign en = !skid_v_q;
	assign seg.ready = en;

	always_comb begin
		in_seg.sp = '{x: seg.start_x, y: seg.start_y, z: seg.start_z, w: seg.start_w};
		in_seg.ep = '{x: seg.end_x, y: seg.end_y, z: seg.end_z, w: seg.end_w};
	end

	npc_clip u_clip (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_v(seg.valid),
		.in_seg(in_seg),
		.near(cfg.near),
		.out_v(clip_v),
		.out_seg(clip_seg),
		.out_clipped(clip_flag)
	);

	npc_proj u_proj (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_v(clip_v),
		.in_seg(clip_seg),
		.in_clipped(clip_flag),
		.cfg(cfg),
		.out_v(res_v),
		.res(res)
	);

	// skid register catches the last stage when the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (en) begin
			skid_v_q <= res_v && !pix.ready;
		end else if (pix.ready) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && res_v && !pix.ready) begin
			skid_q <= res;
		end
	end

	assign out_r = skid_v_q ? skid_q : res;
	assign pix.valid = skid_v_q || res_v;
	assign pix.screen_start_x = out_r.sx;
	assign pix.screen_start_y = out_r.sy;
	assign pix.depth_start = out_r.sd;
	assign pix.screen_end_x = out_r.ex;
	assign pix.screen_end_y = out_r.ey;
	assign pix.depth_end = out_r.ed;
	assign pix.was_clipped = out_r.clipped;

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !pix.ready |=> skid_v_q && $stable(skid_q))
		else $error("skid entry lost while receiver stalled");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		en && res_v && !pix.ready |=> skid_v_q && skid_q == $past(res))
		else $error("stalled result not captured in skid register");

	a_skid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(res_v) && $past(en))
		else $error("skid register filled without a finished result");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && pix.ready |=> !skid_v_q)
		else $error("skid register did not drain on transfer");
endmodule

`default_nettype wire

// File: rtl/npc_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// depends on npc_pkg; quotient is valid when it fits DIV_QW bits, else ovf is set
`default_nettype none

module npc_div (
	input wire logic clk,
	input wire logic en,
	input wire logic [npc_pkg::DIV_NW-1:0] dividend,
	input wire logic [npc_pkg::DIV_DW-1:0] divisor,
	output logic [npc_pkg::DIV_QW-1:0] quo,
	output logic ovf
);
	localparam int NW = npc_pkg::DIV_NW;
	localparam int DW = npc_pkg::DIV_DW;
	localparam int QW = npc_pkg::DIV_QW;

	logic [DW-1:0] rem_s [QW+1];
	logic [QW-1:0] lo_s [QW+1];
	logic [QW-1:0] q_s [QW+1];
	logic [DW-1:0] d_s [QW+1];
	logic ovf_s [QW+1];

	// top part of the dividend seeds the remainder; overflow if it already reaches the divisor
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {1'b0, dividend[NW-1:QW]};
			lo_s[0] <= dividend[QW-1:0];
			q_s[0] <= '0;
			d_s[0] <= divisor;
			ovf_s[0] <= ({1'b0, dividend[NW-1:QW]} >= divisor);
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW:0] r2;
		logic [DW:0] sub;
		logic ge;

		always_comb begin
			r2 = {rem_s[k], lo_s[k][QW-1]};
			sub = r2 - {1'b0, d_s[k]};
			ge = (r2 >= {1'b0, d_s[k]});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? sub[DW-1:0] : r2[DW-1:0];
				lo_s[k+1] <= {lo_s[k][QW-2:0], 1'b0};
				q_s[k+1] <= {q_s[k][QW-2:0], ge};
				d_s[k+1] <= d_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	assign quo = q_s[QW];
	assign ovf = ovf_s[QW];
endmodule

`default_nettype wire

// File: rtl/npc_clip.sv
// near-plane clip pipeline: classify, take differences, multiply, divide, move endpoint
// depends on npc_pkg and npc_div
`default_nettype none

module npc_clip (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic in_v,
	input wire npc_pkg::seg_t in_seg,
	input wire logic [npc_pkg::CW-1:0] near,
	output logic out_v,
	output npc_pkg::seg_t out_seg,
	output logic out_clipped
);
	localparam int CW = npc_pkg::CW;
	localparam int LAT = npc_pkg::DIV_LAT;

	typedef struct packed {
		npc_pkg::seg_t seg;
		logic clip_s;
		logic clip_e;
		logic [2:0] neg;
	} clip_sb_t;

	// stage 1: registered input
	logic v_s1;
	npc_pkg::seg_t seg_s1;

	// stage 2: classification and differences
	logic v_s2, clip_s_s2, clip_e_s2;
	npc_pkg::seg_t seg_s2;
	logic [CW-1:0] a_s2, d_s2;
	logic signed [CW:0] diff_s2 [3];

	// stage 3: magnitudes
	logic v_s3, clip_s_s3, clip_e_s3;
	npc_pkg::seg_t seg_s3;
	logic [CW-1:0] a_s3, d_s3;
	logic [CW-1:0] mag_s3 [3];
	logic [2:0] neg_s3;

	// stage 4: products
	logic v_s4, clip_s_s4, clip_e_s4;
	npc_pkg::seg_t seg_s4;
	logic [CW-1:0] d_s4;
	logic [2*CW-1:0] prod_s4 [3];
	logic [2:0] neg_s4;

	logic [LAT-1:0] vd_s;
	clip_sb_t sb_s [LAT];
	logic [npc_pkg::DIV_QW-1:0] quo [3];
	logic [2:0] quo_ovf;

	logic v_s5, clipped_s5;
	npc_pkg::seg_t seg_s5;

	logic behind_s, behind_e, keep, clip_s, clip_e;
	npc_pkg::point_t in_p, out_p;
	npc_pkg::coord_t in_c [3];
	npc_pkg::coord_t out_c [3];
	logic signed [CW:0] diff [3];
	logic [CW-1:0] a_w, d_w;

	always_comb begin
		behind_s = (seg_s1.sp.w < $signed(near));
		behind_e = (seg_s1.ep.w < $signed(near));
		keep = !(behind_s && behind_e);
		clip_s = behind_s && !behind_e;
		clip_e = behind_e && !behind_s;
		// the endpoint in front is the anchor, the one behind moves toward it
		in_p = clip_s ? seg_s1.ep : seg_s1.sp;
		out_p = clip_s ? seg_s1.sp : seg_s1.ep;
		in_c[0] = in_p.x;
		in_c[1] = in_p.y;
		in_c[2] = in_p.z;
		out_c[0] = out_p.x;
		out_c[1] = out_p.y;
		out_c[2] = out_p.z;
		for (int k = 0; k < 3; k++) begin
			diff[k] = {out_c[k][CW-1], out_c[k]} - {in_c[k][CW-1], in_c[k]};
		end
		a_w = in_p.w - near;
		d_w = in_p.w - out_p.w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1 && keep;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s1 <= in_seg;

			seg_s2 <= seg_s1;
			clip_s_s2 <= clip_s;
			clip_e_s2 <= clip_e;
			a_s2 <= a_w;
			d_s2 <= d_w;
			for (int k = 0; k < 3; k++) begin
				diff_s2[k] <= diff[k];
			end

			seg_s3 <= seg_s2;
			clip_s_s3 <= clip_s_s2;
			clip_e_s3 <= clip_e_s2;
			a_s3 <= a_s2;
			d_s3 <= d_s2;
			for (int k = 0; k < 3; k++) begin
				neg_s3[k] <= diff_s2[k][CW];
				mag_s3[k] <= diff_s2[k][CW] ? CW'(-diff_s2[k]) : CW'(diff_s2[k]);
			end

			seg_s4 <= seg_s3;
			clip_s_s4 <= clip_s_s3;
			clip_e_s4 <= clip_e_s3;
			d_s4 <= d_s3;
			neg_s4 <= neg_s3;
			for (int k = 0; k < 3; k++) begin
				prod_s4[k] <= mag_s3[k] * a_s3;
			end
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_div
		npc_div u_div (
			.clk(clk),
			.en(en),
			.dividend(prod_s4[k]),
			.divisor(d_s4),
			.quo(quo[k]),
			.ovf(quo_ovf[k])
		);
	end

	// sideband rides alongside the divider stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vd_s <= '0;
		end else if (en) begin
			vd_s <= {vd_s[LAT-2:0], v_s4};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s[0] <= '{seg: seg_s4, clip_s: clip_s_s4, clip_e: clip_e_s4, neg: neg_s4};
			for (int i = 1; i < LAT; i++) begin
				sb_s[i] <= sb_s[i-1];
			end
		end
	end

	clip_sb_t sb_o;
	npc_pkg::point_t anc, moved;
	npc_pkg::coord_t anc_c [3];
	npc_pkg::coord_t new_c [3];
	npc_pkg::seg_t seg_n;

	always_comb begin
		sb_o = sb_s[LAT-1];
		anc = sb_o.clip_s ? sb_o.seg.ep : sb_o.seg.sp;
		anc_c[0] = anc.x;
		anc_c[1] = anc.y;
		anc_c[2] = anc.z;
		// the moved point lies between the endpoints, so the low bits are exact
		for (int k = 0; k < 3; k++) begin
			new_c[k] = sb_o.neg[k] ? anc_c[k] - quo[k][CW-1:0]
				: anc_c[k] + quo[k][CW-1:0];
		end
		moved = '{x: new_c[0], y: new_c[1], z: new_c[2], w: near};
		seg_n = sb_o.seg;
		if (sb_o.clip_e) begin
			seg_n.ep = moved;
		end
		if (sb_o.clip_s) begin
			seg_n.sp = moved;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= vd_s[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s5 <= seg_n;
			clipped_s5 <= sb_o.clip_s || sb_o.clip_e;
		end
	end

	assign out_v = v_s5;
	assign out_seg = seg_s5;
	assign out_clipped = clipped_s5;
endmodule

`default_nettype wire

// File: rtl/npc_proj.sv
// projection pipeline: perspective divide and viewport mapping of both endpoints
// depends on npc_pkg and npc_div; six dividers, one per output value
`default_nettype none

module npc_proj (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic in_v,
	input wire npc_pkg::seg_t in_seg,
	input wire logic in_clipped,
	input wire npc_pkg::cfg_t cfg,
	output logic out_v,
	output npc_pkg::res_t res
);
	localparam int CW = npc_pkg::CW;
	localparam int SW = npc_pkg::SIZE_W;
	localparam int FRAC = npc_pkg::FRAC;
	localparam int NW = npc_pkg::DIV_NW;
	localparam int QW = npc_pkg::DIV_QW;
	localparam int LAT = npc_pkg::DIV_LAT;
	localparam int PW = CW + SW;
	localparam logic [QW-1:0] POS_LIM = {{(QW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic [QW-1:0] NEG_LIM = POS_LIM + QW'(1);
	localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

	function automatic logic [CW-1:0] sat(input logic ovf, input logic neg,
		input logic [QW-1:0] q);
		logic [QW-1:0] nq;
		nq = -q;
		if (ovf) begin
			return neg ? CMIN : CMAX;
		end else if (!neg) begin
			return (q > POS_LIM) ? CMAX : q[CW-1:0];
		end else begin
			return (q > NEG_LIM) ? CMIN : nq[CW-1:0];
		end
	endfunction

	logic v_s1, clip_s1;
	npc_pkg::seg_t seg_s1;

	logic v_s2, clip_s2;
	logic signed [CW:0] num_s2 [6];
	logic [CW-1:0] dv_s2 [6];
	logic [SW-1:0] size_s2 [6];

	logic v_s3, clip_s3;
	logic [CW-1:0] mag_s3 [6];
	logic [5:0] neg_s3;
	logic [CW-1:0] dv_s3 [6];
	logic [SW-1:0] size_s3 [6];

	logic v_s4, clip_s4;
	logic [PW-1:0] prod_s4 [6];
	logic [5:0] neg_s4;
	logic [CW-1:0] dv_s4 [6];

	logic [LAT-1:0] vd_s;
	logic [LAT-1:0] clipd_s;
	logic [5:0] negd_s [LAT];

	logic [QW-1:0] quo [6];
	logic [5:0] quo_ovf;

	logic v_s5;
	npc_pkg::res_t res_s5;

	npc_pkg::point_t pt [2];
	logic signed [CW:0] num [6];
	logic [CW-1:0] dv [6];
	logic [SW-1:0] size [6];

	always_comb begin
		pt[0] = seg_s1.sp;
		pt[1] = seg_s1.ep;
		for (int j = 0; j < 2; j++) begin
			num[3*j] = {pt[j].x[CW-1], pt[j].x} + {pt[j].w[CW-1], pt[j].w};
			num[3*j+1] = {pt[j].y[CW-1], pt[j].y} + {pt[j].w[CW-1], pt[j].w};
			num[3*j+2] = {pt[j].z[CW-1], pt[j].z};
			// w is at least the near plane here, so 2w fits unsigned
			dv[3*j] = {pt[j].w[CW-2:0], 1'b0};
			dv[3*j+1] = {pt[j].w[CW-2:0], 1'b0};
			dv[3*j+2] = pt[j].w;
			size[3*j] = cfg.width;
			size[3*j+1] = cfg.height;
			size[3*j+2] = SW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s1 <= in_seg;
			clip_s1 <= in_clipped;

			clip_s2 <= clip_s1;
			num_s2 <= num;
			dv_s2 <= dv;
			size_s2 <= size;

			clip_s3 <= clip_s2;
			dv_s3 <= dv_s2;
			size_s3 <= size_s2;
			for (int k = 0; k < 6; k++) begin
				neg_s3[k] <= num_s2[k][CW];
				mag_s3[k] <= num_s2[k][CW] ? CW'(-num_s2[k]) : CW'(num_s2[k]);
			end

			clip_s4 <= clip_s3;
			dv_s4 <= dv_s3;
			neg_s4 <= neg_s3;
			for (int k = 0; k < 6; k++) begin
				prod_s4[k] <= mag_s3[k] * size_s3[k];
			end
		end
	end

	for (genvar k = 0; k < 6; k++) begin : g_div
		npc_div u_div (
			.clk(clk),
			.en(en),
			.dividend({{(NW-PW-FRAC){1'b0}}, prod_s4[k], {FRAC{1'b0}}}),
			.divisor(dv_s4[k]),
			.quo(quo[k]),
			.ovf(quo_ovf[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vd_s <= '0;
			v_s5 <= 1'b0;
		end else if (en) begin
			vd_s <= {vd_s[LAT-2:0], v_s4};
			v_s5 <= vd_s[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			clipd_s <= {clipd_s[LAT-2:0], clip_s4};
			negd_s[0] <= neg_s4;
			for (int i = 1; i < LAT; i++) begin
				negd_s[i] <= negd_s[i-1];
			end
			res_s5.sx <= sat(quo_ovf[0], negd_s[LAT-1][0], quo[0]);
			res_s5.sy <= sat(quo_ovf[1], negd_s[LAT-1][1], quo[1]);
			res_s5.sd <= sat(quo_ovf[2], negd_s[LAT-1][2], quo[2]);
			res_s5.ex <= sat(quo_ovf[3], negd_s[LAT-1][3], quo[3]);
			res_s5.ey <= sat(quo_ovf[4], negd_s[LAT-1][4], quo[4]);
			res_s5.ed <= sat(quo_ovf[5], negd_s[LAT-1][5], quo[5]);
			res_s5.clipped <= clipd_s[LAT-1];
		end
	end

	assign out_v = v_s5;
	assign res = res_s5;
endmodule

`default_nettype wire
